// ===== hdl/pat_pkg.sv =====
// Shared widths, status codes and result type of the paged address translator.
`default_nettype none

package pat_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned PA_W = 15;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned MASK_W = 16;
  localparam int unsigned MASK_IDX_W = 4;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_FAULT   = 2'd1,
    ST_DENIED  = 2'd2,
    ST_NOFRAME = 2'd3
  } status_e;

  typedef struct packed {
    status_e         status;
    logic [PA_W-1:0] phys_addr;
  } pat_result_t;

endpackage

`default_nettype wire

// ===== hdl/paged_address_translator.sv =====
// Top level of the paged address translator: handshakes, staging and counters.
//
// An access enters on the input channel (logical_address_i, write_access_i) as a
// valid/ready transfer. The page number above OFFSET_WIDTH selects a page table
// entry; an absent page gets the lowest free frame. One result leaves on the
// output channel per access: physical address, status and the saturating access,
// fault and hit counts after that access.
// The read-only mask is written through the configuration channel, which is
// always ready; write it only while no access is in flight.
// An access is held first in the input register and then in the result register.
// The table lookup and the free-frame priority encoder sit between the input
// register and the result register, so one access is taken per cycle while the
// receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// fills; input ready then drops until the result is taken.
// Reset clears the page table, frame usage, counters and the read-only mask.
`default_nettype none

module paged_address_translator import pat_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = 12,
  parameter int unsigned PAGE_COUNT = 16,
  parameter int unsigned FRAME_COUNT = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [MASK_W-1:0] cfg_read_only_mask_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ADDR_W-1:0] logical_address_i,
  input  wire logic              write_access_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [PA_W-1:0]        physical_address_o,
  output logic [1:0]             status_o,
  output logic [CNT_W-1:0]       access_count_o,
  output logic [CNT_W-1:0]       fault_count_o,
  output logic [CNT_W-1:0]       hit_count_o
);

  logic [MASK_W-1:0] ro_mask_q;
  logic              s1_valid_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic              s1_wr_q;
  logic              out_valid_q;
  pat_result_t       out_result_q;
  pat_result_t       lookup;
  logic              s1_advance;
  logic [CNT_W-1:0]  acc_cnt_q;
  logic [CNT_W-1:0]  fault_cnt_q;
  logic [CNT_W-1:0]  hit_cnt_q;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;

  pat_table #(
    .OFFSET_WIDTH(OFFSET_WIDTH),
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (s1_advance),
    .addr_i   (s1_addr_q),
    .wr_i     (s1_wr_q),
    .ro_mask_i(ro_mask_q),
    .result_o (lookup)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ro_mask_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ro_mask_q <= cfg_read_only_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_addr_q <= logical_address_i;
      s1_wr_q <= write_access_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_result_q <= lookup;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cnt_q <= '0;
      fault_cnt_q <= '0;
      hit_cnt_q <= '0;
    end else if (s1_advance) begin
      acc_cnt_q <= sat_inc(acc_cnt_q);
      if (lookup.status == ST_FAULT || lookup.status == ST_NOFRAME) begin
        fault_cnt_q <= sat_inc(fault_cnt_q);
      end
      if (lookup.status == ST_HIT) begin
        hit_cnt_q <= sat_inc(hit_cnt_q);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign physical_address_o = out_result_q.phys_addr;
  assign status_o = out_result_q.status;
  assign access_count_o = acc_cnt_q;
  assign fault_count_o = fault_cnt_q;
  assign hit_count_o = hit_cnt_q;

`ifndef SYNTHESIS
  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !s1_advance)
    else $error("Staged access advanced over a stalled result.");
  a_access_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && acc_cnt_q != '1 |=> acc_cnt_q == $past(acc_cnt_q) + CNT_W'(1))
    else $error("Access count did not advance with a transfer.");
  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_cnt_q <= acc_cnt_q && hit_cnt_q <= acc_cnt_q)
    else $error("Fault or hit count exceeds the access count.");
  a_failed_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_result_q.status == ST_DENIED || out_result_q.status == ST_NOFRAME)
    |-> out_result_q.phys_addr == '0)
    else $error("Failed access reported a nonzero physical address.");
`endif

endmodule

`default_nettype wire

// ===== hdl/pat_table.sv =====
// Page table, frame allocation and address translation for one staged access.
`default_nettype none

module pat_table import pat_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = 12,
  parameter int unsigned PAGE_COUNT = 16,
  parameter int unsigned FRAME_COUNT = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              commit_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic              wr_i,
  input  wire logic [MASK_W-1:0] ro_mask_i,
  output pat_result_t            result_o
);

  localparam int unsigned PAGE_IDX_W = $clog2(PAGE_COUNT);
  localparam int unsigned FRAME_W = $clog2(FRAME_COUNT);

  logic [PAGE_COUNT-1:0][FRAME_W-1:0] page_frame_q;
  logic [PAGE_COUNT-1:0]              page_present_q;
  logic [PAGE_COUNT-1:0]              page_dirty_q;
  logic [PAGE_COUNT-1:0]              page_referenced_q;
  logic [FRAME_COUNT-1:0]             frame_in_use_q;

  logic [ADDR_W-1:0]         page_full;
  logic [PAGE_IDX_W-1:0]     page_idx;
  logic [OFFSET_WIDTH-1:0]   offset;
  logic                      page_valid;
  logic                      write_locked;
  logic                      free_found;
  logic [FRAME_W-1:0]        free_frame;
  logic [FRAME_W-1:0]        frame;
  logic [FRAME_W+OFFSET_WIDTH-1:0] full_pa;
  logic                      allowed;

  assign page_full = addr_i >> OFFSET_WIDTH;
  assign page_idx = page_full[PAGE_IDX_W-1:0];
  assign offset = addr_i[OFFSET_WIDTH-1:0];
  assign page_valid = page_full < ADDR_W'(PAGE_COUNT);
  assign write_locked = (page_full < ADDR_W'(MASK_W)) && ro_mask_i[page_full[MASK_IDX_W-1:0]];

  always_comb begin
    free_found = 1'b0;
    free_frame = '0;
    for (int f = FRAME_COUNT - 1; f >= 0; f--) begin
      if (!frame_in_use_q[f]) begin
        free_found = 1'b1;
        free_frame = FRAME_W'(f);
      end
    end
  end

  always_comb begin
    result_o.status = ST_DENIED;
    frame = page_frame_q[page_idx];
    if (!page_valid || (wr_i && write_locked)) begin
      result_o.status = ST_DENIED;
    end else if (page_present_q[page_idx]) begin
      result_o.status = ST_HIT;
    end else if (free_found) begin
      result_o.status = ST_FAULT;
      frame = free_frame;
    end else begin
      result_o.status = ST_NOFRAME;
    end
    allowed = (result_o.status == ST_HIT) || (result_o.status == ST_FAULT);
    full_pa = {frame, offset};
    result_o.phys_addr = allowed ? PA_W'(full_pa) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_frame_q <= '0;
      page_present_q <= '0;
      page_dirty_q <= '0;
      page_referenced_q <= '0;
      frame_in_use_q <= '0;
    end else if (commit_i && allowed) begin
      page_referenced_q[page_idx] <= 1'b1;
      if (result_o.status == ST_FAULT) begin
        frame_in_use_q[free_frame] <= 1'b1;
        page_frame_q[page_idx] <= free_frame;
        page_present_q[page_idx] <= 1'b1;
        page_dirty_q[page_idx] <= wr_i;
      end else begin
        page_dirty_q[page_idx] <= page_dirty_q[page_idx] | wr_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_fault_uses_free_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && result_o.status == ST_FAULT |-> !frame_in_use_q[free_frame])
    else $error("Fault allocated a frame that is already in use.");
  a_fault_marks_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && result_o.status == ST_FAULT |=> page_present_q[$past(page_idx)])
    else $error("Serviced fault did not mark the page present.");
  a_denied_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && !allowed |=> $stable(frame_in_use_q) && $stable(page_present_q))
    else $error("Denied or unserviced access changed the table.");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the paged address translator with a built-in page table predictor.
`timescale 1ns / 1ps

module testbench;
  import pat_pkg::*;

  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned PAGES = 16;
  localparam int unsigned FRAMES = 8;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              wr;
  } access_t;

  typedef struct packed {
    logic [PA_W-1:0]  pa;
    status_e          status;
    logic [CNT_W-1:0] accesses;
    logic [CNT_W-1:0] faults;
    logic [CNT_W-1:0] hits;
  } translation_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [MASK_W-1:0] cfg_read_only_mask_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ADDR_W-1:0] logical_address_i = '0;
  logic              write_access_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PA_W-1:0]   physical_address_o;
  logic [1:0]        status_o;
  logic [CNT_W-1:0]  access_count_o;
  logic [CNT_W-1:0]  fault_count_o;
  logic [CNT_W-1:0]  hit_count_o;

  paged_address_translator #(
    .OFFSET_WIDTH(OFFSET_W),
    .PAGE_COUNT  (PAGES),
    .FRAME_COUNT (FRAMES)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_read_only_mask_i(cfg_read_only_mask_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .logical_address_i   (logical_address_i),
    .write_access_i      (write_access_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .physical_address_o  (physical_address_o),
    .status_o            (status_o),
    .access_count_o      (access_count_o),
    .fault_count_o       (fault_count_o),
    .hit_count_o         (hit_count_o)
  );

  // Predicted page table, frame usage, counters and read-only mask.
  logic [2:0]        frame_of_page [PAGES];
  logic              page_mapped [PAGES];
  logic              page_dirty [PAGES];
  logic              page_touched [PAGES];
  logic              frame_taken [FRAMES];
  logic [MASK_W-1:0] read_only_pages;
  logic [CNT_W-1:0]  accesses_seen;
  logic [CNT_W-1:0]  faults_seen;
  logic [CNT_W-1:0]  hits_seen;

  access_t      pending_accesses[$];
  translation_t expected_translations[$];
  access_t      next_access;
  translation_t oldest_translation;
  int           mismatch_count = 0;
  int           burst_left = 1;
  int           gap_left = 0;
  int           ready_mode = 0;
  int           ready_left = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] value);
    return (value == COUNT_MAX) ? value : value + CNT_W'(1);
  endfunction

  function automatic translation_t translate_access(access_t acc);
    translation_t        result;
    logic [3:0]          page;
    logic [OFFSET_W-1:0] offset;
    int                  free_frame;
    page = acc.addr[ADDR_W-1:OFFSET_W];
    offset = acc.addr[OFFSET_W-1:0];
    result.pa = '0;
    accesses_seen = bump(accesses_seen);
    if (acc.wr && read_only_pages[page]) begin
      result.status = ST_DENIED;
    end else begin
      if (!page_mapped[page]) begin
        faults_seen = bump(faults_seen);
        free_frame = FRAMES;
        for (int f = FRAMES - 1; f >= 0; f--) begin
          if (!frame_taken[f]) free_frame = f;
        end
        if (free_frame == FRAMES) begin
          result.status = ST_NOFRAME;
        end else begin
          frame_taken[free_frame] = 1'b1;
          frame_of_page[page] = free_frame[2:0];
          page_mapped[page] = 1'b1;
          page_dirty[page] = 1'b0;
          result.status = ST_FAULT;
        end
      end else begin
        hits_seen = bump(hits_seen);
        result.status = ST_HIT;
      end
      if (result.status != ST_NOFRAME) begin
        if (acc.wr) page_dirty[page] = 1'b1;
        page_touched[page] = 1'b1;
        result.pa = {frame_of_page[page], offset};
      end
    end
    result.accesses = accesses_seen;
    result.faults = faults_seen;
    result.hits = hits_seen;
    return result;
  endfunction

  task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    if (mismatch_count < 50) begin
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      logical_address_i <= '0;
      write_access_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_translations.push_back(
          translate_access('{addr: logical_address_i, wr: write_access_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          next_access = pending_accesses.pop_front();
          in_valid_i <= 1'b1;
          logical_address_i <= next_access.addr;
          write_access_i <= next_access.wr;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stretches of full acceptance, random stalls and heavy back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        ready_left = $urandom_range(8, 60);
      end else begin
        ready_left--;
      end
      case (ready_mode)
        0: begin
          out_ready_i <= 1'b1;
        end
        1: begin
          out_ready_i <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_translations.size() == 0) begin
        report_mismatch("result with no access outstanding", CNT_W'(physical_address_o), '0);
      end else begin
        oldest_translation = expected_translations.pop_front();
        if (physical_address_o !== oldest_translation.pa)
          report_mismatch("physical address", CNT_W'(physical_address_o),
                          CNT_W'(oldest_translation.pa));
        if (status_o !== oldest_translation.status)
          report_mismatch("status", CNT_W'(status_o), CNT_W'(oldest_translation.status));
        if (access_count_o !== oldest_translation.accesses)
          report_mismatch("access count", access_count_o, oldest_translation.accesses);
        if (fault_count_o !== oldest_translation.faults)
          report_mismatch("fault count", fault_count_o, oldest_translation.faults);
        if (hit_count_o !== oldest_translation.hits)
          report_mismatch("hit count", hit_count_o, oldest_translation.hits);
      end
    end
  end

  task automatic write_read_only_mask(logic [MASK_W-1:0] mask);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_read_only_mask_i <= mask;
    do @(posedge clk_i); while (!cfg_ready_o);
    read_only_pages = mask;
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_access(logic [ADDR_W-1:0] addr, logic wr);
    pending_accesses.push_back('{addr: addr, wr: wr});
  endtask

  task automatic wait_until_idle(int settle);
    while (pending_accesses.size() != 0 || in_valid_i || expected_translations.size() != 0)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic run_random_phase(logic [MASK_W-1:0] mask, int count);
    logic [OFFSET_W-1:0] offset;
    write_read_only_mask(mask);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: offset = '0;
        1: offset = '1;
        default: offset = OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
      endcase
      queue_access({4'($urandom_range(0, PAGES - 1)), offset}, 1'($urandom_range(0, 1)));
    end
    wait_until_idle(4);
  endtask

  initial begin
    for (int p = 0; p < PAGES; p++) begin
      frame_of_page[p] = '0;
      page_mapped[p] = 1'b0;
      page_dirty[p] = 1'b0;
      page_touched[p] = 1'b0;
    end
    for (int f = 0; f < FRAMES; f++) frame_taken[f] = 1'b0;
    read_only_pages = '0;
    accesses_seen = '0;
    faults_seen = '0;
    hits_seen = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Faults and hits with nothing read-only, offsets at both ends.
    write_read_only_mask(16'h0000);
    queue_access(16'h0000, 1'b0);
    queue_access(16'h0FFF, 1'b0);
    queue_access(16'h0ABC, 1'b1);
    queue_access(16'hF000, 1'b1);
    queue_access(16'hFFFF, 1'b0);
    queue_access(16'h7800, 1'b0);
    wait_until_idle(4);

    // Every page read-only: writes are denied even to absent pages, reads still map.
    write_read_only_mask(16'hFFFF);
    queue_access(16'h0123, 1'b1);
    queue_access(16'h5000, 1'b1);
    queue_access(16'h5000, 1'b0);
    queue_access(16'h1FFF, 1'b0);
    queue_access(16'hF555, 1'b1);
    wait_until_idle(4);

    // Odd pages read-only; the last frames are used up and further faults find none.
    write_read_only_mask(16'hAAAA);
    queue_access(16'h2000, 1'b0);
    queue_access(16'h3AAA, 1'b1);
    queue_access(16'h3555, 1'b0);
    queue_access(16'h4FFF, 1'b1);
    queue_access(16'h6000, 1'b0);
    queue_access(16'h8123, 1'b1);
    queue_access(16'h9000, 1'b1);
    queue_access(16'h0555, 1'b1);
    queue_access(16'hFAAA, 1'b0);
    wait_until_idle(4);

    run_random_phase(16'h5555, 160);
    run_random_phase(16'($urandom), 160);
    run_random_phase(16'h0000, 160);
    run_random_phase(16'hFFFF, 160);
    run_random_phase(16'($urandom), 160);

    wait_until_idle(10);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
